// File: src/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// shared widths, check matrix tables and status codes for the (39,32) codec
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

  localparam int CODE_W  = 39;
  localparam int DATA_W  = 32;
  localparam int CHECK_W = 7;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [CHECK_W-1:0] check_t;
  typedef logic [1:0]         status_t;

  // result status codes
  localparam status_t STAT_CLEAN = 2'd0;
  localparam status_t STAT_FIXED = 2'd1;
  localparam status_t STAT_BAD   = 2'd2;

  // check bits contributed by each data bit
  localparam check_t GEN_ROWS [DATA_W] = '{
    7'h4F, 7'h4A, 7'h52, 7'h54, 7'h57, 7'h58, 7'h5B, 7'h5D,
    7'h23, 7'h25, 7'h26, 7'h29, 7'h2A, 7'h2C, 7'h31, 7'h34,
    7'h0E, 7'h0B, 7'h13, 7'h15, 7'h16, 7'h19, 7'h1A, 7'h1C,
    7'h62, 7'h64, 7'h67, 7'h68, 7'h6B, 7'h6D, 7'h70, 7'h75
  };

  // syndrome column of each codeword bit
  localparam check_t H_COLS [CODE_W] = '{
    7'h40, 7'h20, 7'h10, 7'h08, 7'h04, 7'h02, 7'h01,
    7'h79, 7'h29, 7'h25, 7'h15, 7'h75, 7'h0D, 7'h6D, 7'h5D,
    7'h62, 7'h52, 7'h32, 7'h4A, 7'h2A, 7'h1A, 7'h46, 7'h16,
    7'h38, 7'h68, 7'h64, 7'h54, 7'h34, 7'h4C, 7'h2C, 7'h1C,
    7'h23, 7'h13, 7'h73, 7'h0B, 7'h6B, 7'h5B, 7'h07, 7'h57
  };

  // decoder result bundle
  typedef struct packed {
    code_t   word;
    check_t  syndrome;
    status_t status;
  } dec_res_t;

  // data bits that feed check bit j (evaluated at elaboration)
  function automatic data_t gen_mask(input int j);
    data_t m;
    m = '0;
    for (int i = 0; i < DATA_W; i++) begin
      m[i] = GEN_ROWS[i][j];
    end
    return m;
  endfunction

  // codeword bits that feed syndrome bit j (evaluated at elaboration)
  function automatic code_t col_mask(input int j);
    code_t m;
    m = '0;
    for (int i = 0; i < CODE_W; i++) begin
      m[i] = H_COLS[i][j];
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: src/sdc_encoder.sv
// ----------------------------------------------------------------------------
// sdc_encoder
// builds the 39-bit codeword: check bits in 0..6, data in 7..38
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_encoder (
  input  wire sdc_pkg::data_t data,
  output sdc_pkg::code_t      code
);

  sdc_pkg::check_t chk;

  // one xor tree per check bit
  for (genvar j = 0; j < sdc_pkg::CHECK_W; j++) begin : g_chk
    localparam sdc_pkg::data_t MASK = sdc_pkg::gen_mask(j);
    assign chk[j] = ^(data & MASK);
  end

  assign code = {data, chk};

endmodule

`default_nettype wire

// File: src/sdc_decoder.sv
// ----------------------------------------------------------------------------
// sdc_decoder
// syndrome, single-bit correction and uncorrectable detection
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_decoder (
  input  wire sdc_pkg::code_t word,
  output sdc_pkg::dec_res_t   res
);

  sdc_pkg::check_t syn;
  sdc_pkg::code_t  flip;

  // one xor tree per syndrome bit
  for (genvar j = 0; j < sdc_pkg::CHECK_W; j++) begin : g_syn
    localparam sdc_pkg::code_t MASK = sdc_pkg::col_mask(j);
    assign syn[j] = ^(word & MASK);
  end

  // match syndrome against every column; at most one can hit
  always_comb begin
    for (int i = 0; i < sdc_pkg::CODE_W; i++) begin
      flip[i] = (syn == sdc_pkg::H_COLS[i]);
    end
  end

  // classify and correct
  always_comb begin
    res.word     = word ^ flip;
    res.syndrome = syn;
    if (syn == '0) begin
      res.status = sdc_pkg::STAT_CLEAN;
    end else if (|flip) begin
      res.status = sdc_pkg::STAT_FIXED;
    end else begin
      res.status = sdc_pkg::STAT_BAD;
    end
  end

endmodule

`default_nettype wire

// File: src/secded_39_32_codec.sv
// ----------------------------------------------------------------------------
// secded_39_32_codec
// (39,32) secded encoder and checker/corrector, one word per clock
// ----------------------------------------------------------------------------
// path: an accepted word goes through the input register, then the result register
//   after the xor trees and column compares, which raises the result strobe
// throughput: one word per cycle while busy is low; busy is a registered copy of
//   !rst_n, high during reset and as it is released; the receiver cannot stall
// reset: synchronous active-low rst_n clears the valid flags; no words in flight
`default_nettype none

module secded_39_32_codec (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire                  in_kind,
  input  wire sdc_pkg::code_t  in_word_in,
  output logic                 out_valid,
  output sdc_pkg::code_t       out_word_out,
  output sdc_pkg::check_t      out_syndrome,
  output sdc_pkg::status_t     out_status
);

  logic              busy_r;
  logic              in_vld_r;
  logic              kind_r;
  sdc_pkg::code_t    word_r;
  logic              out_vld_r;
  sdc_pkg::code_t    word_out_r;
  sdc_pkg::check_t   syn_r;
  sdc_pkg::status_t  stat_r;

  logic              accept;
  sdc_pkg::code_t    enc_code;
  sdc_pkg::dec_res_t dec_res;
  sdc_pkg::code_t    word_out_nxt;
  sdc_pkg::check_t   syn_nxt;
  sdc_pkg::status_t  stat_nxt;

  assign accept = start && !busy_r;

  // busy only while coming out of reset
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      word_r <= in_word_in;
    end
  end

  sdc_encoder u_enc (
    .data (word_r[sdc_pkg::DATA_W-1:0]),
    .code (enc_code)
  );

  sdc_decoder u_dec (
    .word (word_r),
    .res  (dec_res)
  );

  // pick encode or decode result
  always_comb begin
    if (kind_r) begin
      word_out_nxt = dec_res.word;
      syn_nxt      = dec_res.syndrome;
      stat_nxt     = dec_res.status;
    end else begin
      word_out_nxt = enc_code;
      syn_nxt      = '0;
      stat_nxt     = sdc_pkg::STAT_CLEAN;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      word_out_r <= word_out_nxt;
      syn_r      <= syn_nxt;
      stat_r     <= stat_nxt;
    end
  end

  assign busy         = busy_r;
  assign out_valid    = out_vld_r;
  assign out_word_out = word_out_r;
  assign out_syndrome = syn_r;
  assign out_status   = stat_r;

endmodule

`default_nettype wire

// File: src/sdc_checker.sv
// ----------------------------------------------------------------------------
// sdc_checker
// port-level checks on the codec, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input wire                  in_kind,
  input wire sdc_pkg::code_t  in_word_in,
  input wire                  out_valid,
  input wire sdc_pkg::code_t  out_word_out,
  input wire sdc_pkg::check_t out_syndrome,
  input wire sdc_pkg::status_t out_status
);

  // every accepted word gives a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  // no strobe without an earlier accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without accepted word");

  // zero syndrome always means clean
  a_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_syndrome == '0) |-> out_status == sdc_pkg::STAT_CLEAN)
    else $error("zero syndrome not reported clean");

  // a correction or failure carries a non-zero syndrome
  a_syn_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == sdc_pkg::STAT_FIXED ||
                   out_status == sdc_pkg::STAT_BAD)) |-> out_syndrome != '0)
    else $error("error status with zero syndrome");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == sdc_pkg::STAT_CLEAN ||
                   out_status == sdc_pkg::STAT_FIXED ||
                   out_status == sdc_pkg::STAT_BAD))
    else $error("undefined status code");

endmodule

bind secded_39_32_codec sdc_checker u_sdc_checker (.*);

`default_nettype wire
